### rtl/core/char_histogram_ordered_query_macros.svh
// Assertion macros shared by the character histogram RTL.
`ifndef CHAR_HISTOGRAM_ORDERED_QUERY_MACROS_SVH
`define CHAR_HISTOGRAM_ORDERED_QUERY_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define CHOQ_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Boolean condition must never be seen outside reset.
`define CHOQ_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) not (cond)) else $error(msg);

`else

`define CHOQ_ASSERT(lbl, ck, rn, prop, msg)
`define CHOQ_ASSERT_NEVER(lbl, ck, rn, cond, msg)

`endif

`endif

### rtl/core/choq_pkg.sv
// Types and constants of the character histogram with ordered seeks.
package choq_pkg;

	// fixed field widths
	localparam int ACT_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int RCOUNT_W = 17;

	// presence bits are scanned one group of this many codes per cycle
	localparam int CHUNK_W = 16;
	localparam int OFF_W   = 4;

	typedef enum logic [ACT_W-1:0] {
		ACT_COUNT     = 2'd0,
		ACT_SEEK_UP   = 2'd1,
		ACT_SEEK_DOWN = 2'd2,
		ACT_CLEAR     = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CNT_UPD,
		ST_SEEK_RD,
		ST_OUT
	} state_t;

	// control of the group scanner
	typedef struct packed {
		logic             down;   // search toward lower codes
		logic             first;  // first group: bound by the key offset
		logic [OFF_W-1:0] off;    // key offset inside the first group
	} scan_ctl_t;

endpackage

### rtl/core/choq_scan.sv
// Group scanner: finds the nearest set presence bit in one group of codes.
module choq_scan (
	input  logic [choq_pkg::CHUNK_W-1:0] bits,
	input  choq_pkg::scan_ctl_t          ctl,
	output logic                         hit,
	output logic [choq_pkg::OFF_W-1:0]   off
);

	logic [choq_pkg::CHUNK_W-1:0] masked;

	// drop codes on the wrong side of the key in the first group
	always_comb begin
		for (int i = 0; i < choq_pkg::CHUNK_W; i++) begin
			if (!ctl.first) begin
				masked[i] = bits[i];
			end else if (ctl.down) begin
				masked[i] = bits[i] && (choq_pkg::OFF_W'(i) <= ctl.off);
			end else begin
				masked[i] = bits[i] && (choq_pkg::OFF_W'(i) >= ctl.off);
			end
		end
	end

	// priority encode: lowest set bit going up, highest going down
	always_comb begin
		hit = |masked;
		off = '0;
		if (ctl.down) begin
			for (int i = 0; i < choq_pkg::CHUNK_W; i++) begin
				if (masked[i]) off = choq_pkg::OFF_W'(i);
			end
		end else begin
			for (int i = choq_pkg::CHUNK_W - 1; i >= 0; i--) begin
				if (masked[i]) off = choq_pkg::OFF_W'(i);
			end
		end
	end

endmodule

### rtl/core/choq_cnt_mem.sv
// Count memory: one write port, one read port with registered data.
module choq_cnt_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/char_histogram_ordered_query.sv
// Top level of the character histogram with ordered seeks.
//
//   channel  signals                          dir  accepted when
//   in       in_valid, action, char_code      in   in_valid && !in_stall
//   out      out_valid, found, result_char,   out  out_valid && !out_stall
//            result_count
//
// Count: accept, read-modify-write of the count memory, output. Seek: accept, then
// scan groups of 16 codes (up to 16 groups at 256 codes) one by one, then on a hit
// a count read and output, or on a miss output alone. Clear, and count or seek up
// beyond the alphabet: accept, then output. Presence bits are flops that reset and
// clear empty at once; no clearing pass. A stalled output holds the next finished
// result in the sequencer until the output register frees.
`include "char_histogram_ordered_query_macros.svh"

module char_histogram_ordered_query #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_WIDTH   = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [choq_pkg::ACT_W-1:0]    action,
	input  logic [choq_pkg::CHAR_W-1:0]   char_code,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [choq_pkg::CHAR_W-1:0]   result_char,
	output logic [choq_pkg::RCOUNT_W-1:0] result_count
);

	// only codes reachable by char_code are stored
	localparam int CODES  = 1 << choq_pkg::CHAR_W;
	localparam int DEPTH  = (ALPHABET_SIZE < CODES) ? ALPHABET_SIZE : CODES;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int NCHUNK = (DEPTH + choq_pkg::CHUNK_W - 1) / choq_pkg::CHUNK_W;
	localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int PAD_W  = NCHUNK * choq_pkg::CHUNK_W;
	localparam int POS_W  = CH_W + choq_pkg::OFF_W;
	localparam int KEXT_W = choq_pkg::CHAR_W + 1;

	choq_pkg::state_t state_q, state_d;

	logic [DEPTH-1:0]              pres_q;
	logic [PAD_W-1:0]              pres_pad;
	logic [choq_pkg::CHAR_W-1:0]   key_q;
	choq_pkg::act_t                act_q;
	logic [CH_W-1:0]               chunk_q;
	logic                          first_q;
	logic [choq_pkg::OFF_W-1:0]    off_q;
	logic [POS_W-1:0]              pos_q;
	logic                          res_found_q;
	logic [choq_pkg::CHAR_W-1:0]   res_char_q;
	logic [choq_pkg::RCOUNT_W-1:0] res_count_q;
	logic                          out_valid_q;
	logic                          out_found_q;
	logic [choq_pkg::CHAR_W-1:0]   out_char_q;
	logic [choq_pkg::RCOUNT_W-1:0] out_count_q;

	choq_pkg::act_t                act_in;
	logic                          in_acc;
	logic                          in_range;
	logic [choq_pkg::CHAR_W-1:0]   start_key;
	logic [IDX_W-1:0]              key_idx;
	logic                          out_free;
	logic                          load_out;
	logic                          chunk_end;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_raddr;
	logic [COUNT_WIDTH-1:0]        mem_rdata;
	logic [COUNT_WIDTH-1:0]        cnt_old;
	logic [COUNT_WIDTH-1:0]        cnt_new;
	logic [POS_W-1:0]              hit_pos;
	choq_pkg::scan_ctl_t           scan_ctl;
	logic                          scan_hit;
	logic [choq_pkg::OFF_W-1:0]    scan_off;

	// input decode
	assign act_in   = choq_pkg::act_t'(action);
	assign in_acc   = in_valid && !in_stall;
	assign in_range = {1'b0, char_code} < KEXT_W'(DEPTH);
	assign key_idx  = key_q[IDX_W-1:0];
	// seek down from beyond the alphabet starts at its top code
	assign start_key = (act_in == choq_pkg::ACT_SEEK_DOWN && !in_range) ?
		choq_pkg::CHAR_W'(DEPTH - 1) : char_code;

	// presence bits padded to whole groups
	always_comb begin
		pres_pad = '0;
		pres_pad[DEPTH-1:0] = pres_q;
	end

	// shared group scanner
	assign scan_ctl.down  = (act_q == choq_pkg::ACT_SEEK_DOWN);
	assign scan_ctl.first = first_q;
	assign scan_ctl.off   = off_q;

	choq_scan u_scan (
		.bits (pres_pad[chunk_q * choq_pkg::CHUNK_W +: choq_pkg::CHUNK_W]),
		.ctl  (scan_ctl),
		.hit  (scan_hit),
		.off  (scan_off)
	);

	assign hit_pos   = {chunk_q, scan_off};
	assign chunk_end = scan_ctl.down ? (chunk_q == '0) : (chunk_q == CH_W'(NCHUNK - 1));

	// count memory, gated by presence so stale entries read as zero
	choq_cnt_mem #(
		.DEPTH (DEPTH),
		.WIDTH (COUNT_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (key_idx),
		.wdata (cnt_new),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cnt_old = pres_q[key_idx] ? mem_rdata : '0;
	assign cnt_new = (cnt_old == {COUNT_WIDTH{1'b1}}) ? cnt_old :
		cnt_old + COUNT_WIDTH'(1);

	// output register handshake
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			choq_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (act_in)
						choq_pkg::ACT_COUNT:
							state_d = in_range ? choq_pkg::ST_CNT_UPD : choq_pkg::ST_OUT;
						choq_pkg::ACT_SEEK_UP:
							state_d = in_range ? choq_pkg::ST_SCAN : choq_pkg::ST_OUT;
						choq_pkg::ACT_SEEK_DOWN: state_d = choq_pkg::ST_SCAN;
						default:                 state_d = choq_pkg::ST_OUT;
					endcase
				end
			end
			choq_pkg::ST_SCAN: begin
				if (scan_hit) state_d = choq_pkg::ST_SEEK_RD;
				else if (chunk_end) state_d = choq_pkg::ST_OUT;
			end
			choq_pkg::ST_CNT_UPD: state_d = choq_pkg::ST_OUT;
			choq_pkg::ST_SEEK_RD: state_d = choq_pkg::ST_OUT;
			choq_pkg::ST_OUT: begin
				if (out_free) state_d = choq_pkg::ST_IDLE;
			end
			default: state_d = choq_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		load_out  = 1'b0;
		mem_raddr = hit_pos[IDX_W-1:0];
		case (state_q)
			choq_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				mem_raddr = char_code[IDX_W-1:0];
			end
			choq_pkg::ST_SCAN:    mem_raddr = hit_pos[IDX_W-1:0];
			choq_pkg::ST_CNT_UPD: mem_we = 1'b1;
			choq_pkg::ST_SEEK_RD: mem_we = 1'b0;
			choq_pkg::ST_OUT:     load_out = out_free;
			default:              in_stall = 1'b1;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= choq_pkg::ST_IDLE;
			pres_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && act_in == choq_pkg::ACT_CLEAR) pres_q <= '0;
			else if (mem_we) pres_q[key_idx] <= 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			choq_pkg::ST_IDLE: begin
				if (in_acc) begin
					key_q       <= char_code;
					act_q       <= act_in;
					first_q     <= 1'b1;
					chunk_q     <= CH_W'(start_key >> choq_pkg::OFF_W);
					off_q       <= start_key[choq_pkg::OFF_W-1:0];
					res_found_q <= 1'b0;
					res_char_q  <= (act_in == choq_pkg::ACT_COUNT) ? char_code : '0;
					res_count_q <= '0;
				end
			end
			choq_pkg::ST_SCAN: begin
				first_q <= 1'b0;
				pos_q   <= hit_pos;
				// step one group toward the search direction
				if (!scan_hit && !chunk_end) begin
					if (scan_ctl.down) chunk_q <= chunk_q - CH_W'(1);
					else chunk_q <= chunk_q + CH_W'(1);
				end
			end
			choq_pkg::ST_CNT_UPD: begin
				res_found_q <= 1'b1;
				res_char_q  <= key_q;
				res_count_q <= choq_pkg::RCOUNT_W'(cnt_new);
			end
			choq_pkg::ST_SEEK_RD: begin
				res_found_q <= 1'b1;
				res_char_q  <= choq_pkg::CHAR_W'(pos_q);
				res_count_q <= choq_pkg::RCOUNT_W'(mem_rdata);
			end
			default: ;
		endcase
		if (load_out) begin
			out_found_q <= res_found_q;
			out_char_q  <= res_char_q;
			out_count_q <= res_count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign result_char  = out_char_q;
	assign result_count = out_count_q;

	// checks
	`CHOQ_ASSERT(a_count_sets_pres, clk, arst_n, (state_q == choq_pkg::ST_CNT_UPD) |=> pres_q[key_idx], "counted character not marked present")
	`CHOQ_ASSERT(a_clear_empties, clk, arst_n, (in_acc && act_in == choq_pkg::ACT_CLEAR) |=> (pres_q == '0), "clear left characters present")
	`CHOQ_ASSERT_NEVER(a_seek_hit_present, clk, arst_n, (state_q == choq_pkg::ST_SEEK_RD) && !pres_pad[pos_q], "seek hit on absent character")
	`CHOQ_ASSERT_NEVER(a_busy_accept, clk, arst_n, in_acc && (state_q != choq_pkg::ST_IDLE), "item taken while busy")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the character histogram with ordered seeks.
module testbench;

	localparam int ALPHA       = 256;
	localparam int COUNT_MAX   = (1 << choq_pkg::RCOUNT_W) - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_OPS  = 1450;
	localparam int QUIET_OPS   = 200;
	localparam int COUNT_RUN   = 300;

	// one expected reply of the block
	typedef struct packed {
		logic                          hit;
		logic [choq_pkg::CHAR_W-1:0]   code;
		logic [choq_pkg::RCOUNT_W-1:0] tally;
	} hist_reply_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [choq_pkg::ACT_W-1:0]    action = choq_pkg::ACT_COUNT;
	logic [choq_pkg::CHAR_W-1:0]   char_code = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          found;
	logic [choq_pkg::CHAR_W-1:0]   result_char;
	logic [choq_pkg::RCOUNT_W-1:0] result_count;

	// shadow histogram
	logic [choq_pkg::RCOUNT_W-1:0] tally_counts [ALPHA] = '{default: '0};
	logic                          seen_bits [ALPHA] = '{default: 1'b0};

	hist_reply_t                   expected_replies [$];
	int                            mismatch_count = 0;
	int                            ops_sent = 0;
	bit                            sender_idle_on = 1'b1;
	bit                            stall_idle_on = 1'b1;
	int                            stall_burst = 0;
	logic [choq_pkg::CHAR_W-1:0]   hot_codes [8];

	char_histogram_ordered_query #(
		.ALPHABET_SIZE(ALPHA),
		.COUNT_WIDTH(choq_pkg::RCOUNT_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.result_char(result_char),
		.result_count(result_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// smallest present code at or above key, -1 if none
	function automatic int next_present_up(int key);
		for (int i = key; i < ALPHA; i++)
			if (seen_bits[i]) return i;
		return -1;
	endfunction

	// largest present code at or below key, -1 if none
	function automatic int next_present_down(int key);
		for (int i = key; i >= 0; i--)
			if (seen_bits[i]) return i;
		return -1;
	endfunction

	// apply one accepted item to the shadow histogram, return its reply
	function automatic hist_reply_t apply_histogram_op(choq_pkg::act_t act,
		logic [choq_pkg::CHAR_W-1:0] key);
		hist_reply_t r;
		int          pos;
		r = '0;
		pos = -1;
		case (act)
			choq_pkg::ACT_COUNT: begin
				if (tally_counts[key] != COUNT_MAX)
					tally_counts[key] = tally_counts[key] + 1'b1;
				seen_bits[key] = 1'b1;
				r.hit   = 1'b1;
				r.code  = key;
				r.tally = tally_counts[key];
			end
			choq_pkg::ACT_SEEK_UP:   pos = next_present_up(key);
			choq_pkg::ACT_SEEK_DOWN: pos = next_present_down(key);
			default: begin
				foreach (tally_counts[i]) begin
					tally_counts[i] = '0;
					seen_bits[i]    = 1'b0;
				end
			end
		endcase
		if (pos >= 0) begin
			r.hit   = 1'b1;
			r.code  = pos[choq_pkg::CHAR_W-1:0];
			r.tally = tally_counts[pos];
		end
		return r;
	endfunction

	// drive one item from a falling edge, hold it until accepted, record its reply
	task automatic send_op(input choq_pkg::act_t act, input logic [choq_pkg::CHAR_W-1:0] key);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid  = 1'b1;
		action    = act;
		char_code = key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_replies.push_back(apply_histogram_op(act, key));
		ops_sent++;
		@(negedge clk);
	endtask

	// hold the input off until every outstanding reply has come back
	task automatic drain_replies();
		in_valid = 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stall bursts
	always @(negedge clk) begin
		if (stall_burst == 0 && stall_idle_on && $urandom_range(0, 5) == 0)
			stall_burst = $urandom_range(1, 16);
		if (stall_burst > 0) begin
			out_stall = 1'b1;
			stall_burst--;
		end else begin
			out_stall = 1'b0;
		end
	end

	// compare each accepted reply with the oldest expectation
	always @(posedge clk) begin : check_replies
		hist_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				$error("reply with nothing expected: found %0d char %0d count %0d",
					found, result_char, result_count);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (found !== want.hit) begin
					$error("found: expected %0d, got %0d", want.hit, found);
					mismatch_count++;
				end
				if (result_char !== want.code) begin
					$error("result_char: expected %0d, got %0d", want.code, result_char);
					mismatch_count++;
				end
				if (result_count !== want.tally) begin
					$error("result_count: expected %0d, got %0d", want.tally, result_count);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when neither channel moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// seeks on an empty table find nothing
	task automatic test_empty_seeks();
		send_op(choq_pkg::ACT_SEEK_UP, 8'h00);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'hFF);
		send_op(choq_pkg::ACT_SEEK_UP, 8'hFF);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'h00);
	endtask

	// counts at the code extremes, seeks landing on and between them
	task automatic test_count_and_seek();
		send_op(choq_pkg::ACT_COUNT, 8'h00);
		send_op(choq_pkg::ACT_COUNT, 8'hFF);
		send_op(choq_pkg::ACT_COUNT, 8'h80);
		send_op(choq_pkg::ACT_COUNT, 8'h80);
		send_op(choq_pkg::ACT_SEEK_UP, 8'h00);
		send_op(choq_pkg::ACT_SEEK_UP, 8'h01);
		send_op(choq_pkg::ACT_SEEK_UP, 8'h81);
		send_op(choq_pkg::ACT_SEEK_UP, 8'hFF);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'hFF);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'hFE);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'h7F);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'h00);
		send_op(choq_pkg::ACT_COUNT, 8'h55);
		send_op(choq_pkg::ACT_COUNT, 8'hAA);
	endtask

	// clear empties the table, also when already empty
	task automatic test_clear();
		send_op(choq_pkg::ACT_CLEAR, 8'h00);
		send_op(choq_pkg::ACT_SEEK_UP, 8'h00);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'hFF);
		send_op(choq_pkg::ACT_CLEAR, 8'hFF);
		send_op(choq_pkg::ACT_COUNT, 8'h7F);
	endtask

	// long run of counts on one code, back to back with no idling
	task automatic test_count_run();
		sender_idle_on = 1'b0;
		stall_idle_on  = 1'b0;
		repeat (COUNT_RUN) send_op(choq_pkg::ACT_COUNT, 8'h3C);
		send_op(choq_pkg::ACT_SEEK_UP, 8'h00);
		send_op(choq_pkg::ACT_SEEK_DOWN, 8'hFF);
		send_op(choq_pkg::ACT_CLEAR, 8'h00);
		sender_idle_on = 1'b1;
		stall_idle_on  = 1'b1;
	endtask

	function automatic logic [choq_pkg::CHAR_W-1:0] pick_code();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if (sel <= 5) return hot_codes[$urandom_range(0, 7)];
		return choq_pkg::CHAR_W'($urandom_range(0, 255));
	endfunction

	// walk the table in order from one end, as an ordered report does
	task automatic scan_table(input bit upward);
		int key;
		int pos;
		key = upward ? 0 : ALPHA - 1;
		while (key >= 0 && key < ALPHA) begin
			send_op(upward ? choq_pkg::ACT_SEEK_UP : choq_pkg::ACT_SEEK_DOWN,
				key[choq_pkg::CHAR_W-1:0]);
			pos = upward ? next_present_up(key) : next_present_down(key);
			if (pos < 0) break;
			key = upward ? pos + 1 : pos - 1;
		end
	endtask

	// mixed traffic over a small set of busy codes with occasional scans
	task automatic test_random_traffic();
		int start;
		int sel;
		bit drained;
		foreach (hot_codes[i]) hot_codes[i] = choq_pkg::CHAR_W'($urandom_range(0, 255));
		start = ops_sent;
		drained = 1'b0;
		while (ops_sent - start < RANDOM_OPS) begin
			if (ops_sent - start >= RANDOM_OPS - QUIET_OPS) begin
				sender_idle_on = 1'b0;
				stall_idle_on  = 1'b0;
			end else if ((ops_sent - start) % 150 == 0) begin
				sender_idle_on = $urandom_range(0, 3) != 0;
				stall_idle_on  = $urandom_range(0, 3) != 0;
			end
			if (!drained && (ops_sent - start) >= RANDOM_OPS / 2) begin
				drain_replies();
				drained = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 2)
				scan_table(1'($urandom_range(0, 1)));
			else if (sel < 46)
				send_op(choq_pkg::ACT_COUNT, pick_code());
			else if (sel < 72)
				send_op(choq_pkg::ACT_SEEK_UP, pick_code());
			else if (sel < 98)
				send_op(choq_pkg::ACT_SEEK_DOWN, pick_code());
			else begin
				send_op(choq_pkg::ACT_CLEAR, choq_pkg::CHAR_W'($urandom_range(0, 255)));
				foreach (hot_codes[i]) hot_codes[i] = choq_pkg::CHAR_W'($urandom_range(0, 255));
			end
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_seeks();
		test_count_and_seek();
		test_clear();
		test_count_run();
		test_random_traffic();
		in_valid = 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/choq_pkg.sv
rtl/core/choq_scan.sv
rtl/core/choq_cnt_mem.sv
rtl/core/char_histogram_ordered_query.sv
tb/sv/testbench.sv
